[rtl/gdw_pkg.sv]
// ----------------------------------------------------------------------------
// gdw_pkg
// Shared types, constants and the 2^(-j/16) table for the Gaussian
// third-derivative wavelet generator.
// ----------------------------------------------------------------------------
package gdw_pkg;

  localparam int DEFAULT_SAMPLE_COUNT = 65536;

  // register indexes
  localparam logic [1:0] REG_FREQ   = 2'd0;
  localparam logic [1:0] REG_PERIOD = 2'd1;
  localparam logic [1:0] REG_SHIFT  = 2'd2;

  localparam logic [7:0]  FREQ_RESET   = 8'd25;
  localparam logic [15:0] SHIFT_RESET  = 16'd80;
  // round(500000 ns * 2^32 / 1e9)
  localparam logic [22:0] DT_Q32_RESET = 23'd2147484;

  // period conversion: floor(2^62 / 1e9), half and whole seconds in ns
  localparam logic [32:0] DT_RECIP   = 33'd4611686018;
  localparam logic [31:0] HALF_S     = 32'd500000000;
  localparam logic [31:0] NS_PER_S   = 32'd1000000000;
  localparam logic [31:0] TWO_S      = 32'd2000000000;

  localparam logic [30:0] PI_Q29     = 31'd1686629713;
  localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
  localparam logic [20:0] TWOKPI_Q8  = 21'd1608495;
  localparam logic [30:0] THREE_Q24  = 31'd50331648;

  typedef struct packed {
    logic [7:0]  freq;
    logic [22:0] dt_q32;
    logic [15:0] shift;
  } cfg_t;

  // 2^(-j/16) in Q1.16, j = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] j);
    logic [16:0] r;
    case (j)
      5'd0:    r = 17'd65536;
      5'd1:    r = 17'd62757;
      5'd2:    r = 17'd60097;
      5'd3:    r = 17'd57549;
      5'd4:    r = 17'd55109;
      5'd5:    r = 17'd52773;
      5'd6:    r = 17'd50535;
      5'd7:    r = 17'd48393;
      5'd8:    r = 17'd46341;
      5'd9:    r = 17'd44376;
      5'd10:   r = 17'd42495;
      5'd11:   r = 17'd40693;
      5'd12:   r = 17'd38968;
      5'd13:   r = 17'd37316;
      5'd14:   r = 17'd35734;
      5'd15:   r = 17'd34219;
      default: r = 17'd32768;
    endcase
    return r;
  endfunction

endpackage

[rtl/gdw_pipe.sv]
// ----------------------------------------------------------------------------
// gdw_pipe
// Eleven-stage datapath: time offset, argument, exp(-a^2) by table and
// interpolation, polynomial, scaling and saturation.
// ----------------------------------------------------------------------------
module gdw_pipe #(
  parameter int SAMPLE_COUNT = gdw_pkg::DEFAULT_SAMPLE_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_take,
  input  logic [15:0]         idx,
  input  gdw_pkg::cfg_t       cfg,
  output logic                out_vld,
  output logic [31:0]         out_word
);

  logic [11:1] vld;

  // per-stage payload
  logic [15:0] dist1;
  logic        tneg1, zero1;
  logic [38:0] tmag2;
  logic        tneg2, zero2;
  logic [32:0] p3;
  logic        tneg3, zero3;
  logic [26:0] arg4, arg5, arg6, arg7, arg8;
  logic        tneg4, zero4, tneg5, zero5;
  logic [29:0] x5;
  logic [30:0] y6, pmag6, pmag7, pmag8, pmag9;
  logic        sgn6, sgn7, sgn8, sgn9, sgn10;
  logic        zero6, zero7, zero8, zero9, zero10;
  logic [16:0] e7;
  logic [27:0] m1_8;
  logic [34:0] m2_9;
  logic [39:0] m3_10;
  logic        big10;

  // combinational pieces
  logic [38:0] tmag_c;
  logic [46:0] p_c;
  logic [63:0] argp_c;
  logic [53:0] sq_c;
  logic [60:0] yp_c;
  logic [30:0] twox_c;
  logic [6:0]  k_c;
  logic [4:0]  j_c;
  logic [16:0] hi_c, lo_c, v_c;
  logic [11:0] diff_c;
  logic [31:0] ip_c;
  logic [43:0] m1p_c;
  logic [58:0] m2p_c;
  logic [42:0] m3_c;
  logic [60:0] magp_c;
  logic [36:0] mag_c;

  assign tmag_c = 39'(dist1) * 39'(cfg.dt_q32);
  assign p_c    = 47'(tmag2) * 47'(cfg.freq);
  assign argp_c = 64'(p3) * 64'(gdw_pkg::PI_Q29);
  assign sq_c   = 54'(arg4) * 54'(arg4);
  assign yp_c   = 61'(x5) * 61'(gdw_pkg::LOG2E_Q30);
  assign twox_c = {x5, 1'b0};

  assign k_c    = y6[30:24];
  assign j_c    = {1'b0, y6[23:20]};
  assign hi_c   = gdw_pkg::pow2_neg(j_c);
  assign lo_c   = gdw_pkg::pow2_neg(j_c + 5'd1);
  assign diff_c = 12'(hi_c - lo_c);
  assign ip_c   = 32'(diff_c) * 32'(y6[19:0]) + 32'd524288;
  assign v_c    = hi_c - 17'(ip_c[31:20]);

  assign m1p_c  = 44'(arg7) * 44'(e7);
  assign m2p_c  = 59'(m1_8) * 59'(pmag8);
  assign m3_c   = 43'(m2_9) * 43'(cfg.freq);
  assign magp_c = 61'(m3_10) * 61'(gdw_pkg::TWOKPI_Q8);
  assign mag_c  = big10 ? {37{1'b1}} : magp_c[60:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[10:1], in_take};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: offset from center
      tneg1 <= idx < cfg.shift;
      dist1 <= (idx < cfg.shift) ? cfg.shift - idx : idx - cfg.shift;
      zero1 <= {1'b0, idx} >= 17'(SAMPLE_COUNT);
      // stage 2: |t| in Q7.32
      tmag2 <= tmag_c;
      tneg2 <= tneg1;
      zero2 <= zero1;
      // stage 3: f*|t|, far tail check
      p3    <= p_c[32:0];
      tneg3 <= tneg2;
      zero3 <= zero2 | (|p_c[46:33]);
      // stage 4: a = pi*f*t in Q3.24
      arg4  <= argp_c[63:37];
      tneg4 <= tneg3;
      zero4 <= zero3;
      // stage 5: a^2
      x5    <= sq_c[53:24];
      arg5  <= arg4;
      tneg5 <= tneg4;
      zero5 <= zero4;
      // stage 6: exponent in base 2, polynomial 3 - 2x
      y6    <= yp_c[60:30];
      pmag6 <= (twox_c > gdw_pkg::THREE_Q24) ? twox_c - gdw_pkg::THREE_Q24
                                              : gdw_pkg::THREE_Q24 - twox_c;
      sgn6  <= tneg5 == (twox_c > gdw_pkg::THREE_Q24);
      arg6  <= arg5;
      zero6 <= zero5;
      // stage 7: table + linear interpolation, shift by integer part
      e7    <= (k_c >= 7'd17) ? 17'd0 : v_c >> k_c;
      arg7  <= arg6;
      pmag7 <= pmag6;
      sgn7  <= sgn6;
      zero7 <= zero6;
      // stage 8
      m1_8  <= m1p_c[43:16];
      pmag8 <= pmag7;
      sgn8  <= sgn7;
      zero8 <= zero7;
      // stage 9
      m2_9  <= m2p_c[58:24];
      sgn9  <= sgn8;
      zero9 <= zero8;
      // stage 10
      m3_10 <= m3_c[39:0];
      big10 <= |m3_c[42:40];
      sgn10 <= sgn9;
      zero10 <= zero9;
      // stage 11: scale and saturate
      if (zero10) begin
        out_word <= 32'd0;
      end else if (sgn10) begin
        out_word <= (mag_c >= 37'h080000000) ? 32'h80000000 : 32'd0 - mag_c[31:0];
      end else begin
        out_word <= (mag_c >= 37'h07FFFFFFF) ? 32'h7FFFFFFF : mag_c[31:0];
      end
    end
  end

  assign out_vld = vld[11];

endmodule

[rtl/gaussian_derivative_wavelet_gen_unit.sv]
// ----------------------------------------------------------------------------
// gaussian_derivative_wavelet_gen_unit
// Gaussian third-derivative wavelet sample generator with register port.
// ----------------------------------------------------------------------------
// One sample index in, one Q24.8 wavelet sample out; a new index is taken
// every cycle while the output side keeps up. The datapath is an
// eleven-stage pipeline with at most one multiplier per stage, and a stall
// at the output holds every stage. Writing sample_period_ns starts a
// conversion of the period to Q0.32 seconds (reciprocal estimate,
// back-multiply, correction by at most two); during it both in_ready and
// cfg_ready are low.
module gaussian_derivative_wavelet_gen_unit #(
  parameter int SAMPLE_COUNT = gdw_pkg::DEFAULT_SAMPLE_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sample_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] sample_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  gdw_pkg::cfg_t cfg;
  logic          busy;
  logic [1:0]    cnt;
  logic [19:0]   per;
  logic [22:0]   quo;
  logic [31:0]   rem;
  logic [52:0]   est_c;
  logic [31:0]   back_c;
  logic [1:0]    fix_c;
  logic          en, cfg_we;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !busy;
  assign cfg_ready = !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  // estimate is low by at most two; the remainder (below 3e9) fits 32 bits
  assign est_c  = 53'(per) * 53'(gdw_pkg::DT_RECIP);
  assign back_c = 32'(quo) * gdw_pkg::NS_PER_S;
  assign fix_c  = {1'b0, rem >= gdw_pkg::NS_PER_S} + {1'b0, rem >= gdw_pkg::TWO_S};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq   <= gdw_pkg::FREQ_RESET;
      cfg.shift  <= gdw_pkg::SHIFT_RESET;
      cfg.dt_q32 <= gdw_pkg::DT_Q32_RESET;
      busy       <= 1'b0;
      cnt        <= '0;
    end else if (busy) begin
      case (cnt)
        2'd2: quo <= est_c[52:30];
        2'd1: rem <= gdw_pkg::HALF_S - back_c;
        default: begin
          cfg.dt_q32 <= quo + 23'(fix_c);
          busy       <= 1'b0;
        end
      endcase
      cnt <= cnt - 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        gdw_pkg::REG_FREQ:  cfg.freq  <= cfg_data[7:0];
        gdw_pkg::REG_SHIFT: cfg.shift <= cfg_data[15:0];
        gdw_pkg::REG_PERIOD: begin
          per  <= cfg_data;
          cnt  <= 2'd2;
          busy <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  gdw_pipe #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_pipe (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_take  (in_valid && in_ready),
    .idx      (sample_index),
    .cfg      (cfg),
    .out_vld  (out_valid),
    .out_word (sample_value)
  );

endmodule

[rtl/gdw_checker.sv]
// ----------------------------------------------------------------------------
// gdw_checker
// Port-level checks for the wavelet generator, bound to the top level.
// ----------------------------------------------------------------------------
module gdw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sample_value,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_value))
    else $error("result changed before transfer");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // period write blocks both channels while dt is converted
  a_period_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == gdw_pkg::REG_PERIOD |=> !in_ready && !cfg_ready)
    else $error("channels open during period conversion");

  a_in_cfg: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cfg_ready)
    else $error("input open while config busy");

endmodule

bind gaussian_derivative_wavelet_gen_unit gdw_checker u_gdw_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .sample_value (sample_value),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready),
  .cfg_index    (cfg_index)
);

[tb/gaussian_derivative_wavelet_gen_unit_test.sv]
// ----------------------------------------------------------------------------
// gaussian_derivative_wavelet_gen_unit_test
// Drives sample indexes through the wavelet generator under several register
// settings, with random idling on both sides, and checks every sample
// against a bit-exact fixed-point predictor held in a small scoreboard.
// ----------------------------------------------------------------------------
module gaussian_derivative_wavelet_gen_unit_test;

  localparam int LATENCY = 11;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] sample_index;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] sample_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  int mismatches = 0;

  gaussian_derivative_wavelet_gen_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample_index(sample_index),
    .out_valid(out_valid), .out_ready(out_ready), .sample_value(sample_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
    mismatches++;
  endtask

  class wavelet_scoreboard;
    logic [7:0]  freq;
    logic [19:0] period_ns;
    logic [15:0] shift;
    logic [31:0] pending[$];

    function void reset_regs();
      freq = 8'd25;
      period_ns = 20'd500000;
      shift = 16'd80;
    endfunction

    function void write_reg(input logic [1:0] idx, input logic [19:0] value);
      if (idx == gdw_pkg::REG_FREQ) freq = value[7:0];
      else if (idx == gdw_pkg::REG_PERIOD) period_ns = value;
      else if (idx == gdw_pkg::REG_SHIFT) shift = value[15:0];
    endfunction

    function logic [63:0] exp_neg_q16(input logic [63:0] x_q24);
      logic [63:0] y, k, rem, hi, lo, v;
      logic [4:0]  j;
      logic [16:0] tab[17];
      tab = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
              44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
      y = (x_q24 * 64'd1549082005) >> 30;
      k = y >> 24;
      j = {1'b0, y[23:20]};
      rem = y & 64'hFFFFF;
      hi = 64'(tab[j]);
      lo = 64'(tab[j + 5'd1]);
      v = hi - (((hi - lo) * rem + 64'd524288) >> 20);
      if (k >= 64'd17) return 64'd0;
      return v >> k;
    endfunction

    function logic [31:0] wavelet_sample(input logic [15:0] idx);
      logic [63:0] offset, dt_q32, p, arg, x, e, twox, pmag, m1, m2, m3, mag;
      logic        t_neg, p_neg;
      t_neg = idx < shift;
      offset = t_neg ? 64'(shift) - 64'(idx) : 64'(idx) - 64'(shift);
      dt_q32 = (({44'd0, period_ns} << 32) + 64'd500000000) / 64'd1000000000;
      p = offset * dt_q32 * 64'(freq);
      if (p >= (64'd1 << 33)) return 32'd0;
      arg = (p * 64'd1686629713) >> 37;
      x = (arg * arg) >> 24;
      e = exp_neg_q16(x);
      twox = 64'd2 * x;
      p_neg = twox > (64'd3 << 24);
      pmag = p_neg ? twox - (64'd3 << 24) : (64'd3 << 24) - twox;
      m1 = (arg * e) >> 16;
      m2 = (m1 * pmag) >> 24;
      m3 = m2 * 64'(freq);
      mag = (m3 >= (64'd1 << 40)) ? 64'hFF_FFFF_FFFF : (m3 * 64'd1608495) >> 24;
      if (t_neg == p_neg)
        return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      return (mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function void note_index(input logic [15:0] idx);
      pending.push_back(wavelet_sample(idx));
    endfunction

    task check_sample(input logic [31:0] got);
      logic [31:0] want;
      if (pending.size() == 0) begin
        report("unexpected sample", got, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got !== want) report("sample_value", got, want);
    endtask
  endclass

  wavelet_scoreboard board;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output side: random stalls, check each transfer
  initial begin
    int stall;
    stall = 0;
    out_ready = 0;
    @(posedge clk iff !rst);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) board.check_sample(sample_value);
      if (stall > 0) begin
        stall--;
        out_ready <= 0;
      end else begin
        out_ready <= 1;
        stall = gap_len();
      end
    end
  end

  // valid stays up between back-to-back transfers; drain() drops it
  task automatic send_index(input logic [15:0] idx);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    sample_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_index(idx);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] value);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, value);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [7:0] f, input logic [19:0] dt,
                          input logic [15:0] sh);
    drain();
    write_reg(gdw_pkg::REG_FREQ, f);
    write_reg(gdw_pkg::REG_PERIOD, dt);
    write_reg(gdw_pkg::REG_SHIFT, sh);
  endtask

  // mostly indexes near the center, where the wavelet is nonzero
  task automatic random_run(input int n);
    int k, span;
    logic [15:0] idx;
    for (k = 0; k < n; k++) begin
      span = $urandom_range(0, 9);
      if (span < 7) idx = 16'(board.shift + $signed($urandom_range(0, 400)) - 200);
      else idx = 16'($urandom);
      send_index(idx);
    end
  endtask

  initial begin
    board = new();
    board.reset_regs();
    rst = 1;
    in_valid = 0;
    sample_index = 0;
    cfg_valid = 0;
    cfg_index = gdw_pkg::REG_FREQ;
    cfg_data = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed, reset registers
    send_index(16'd0);
    send_index(16'd65535);
    send_index(16'd80);
    send_index(16'd79);
    send_index(16'd81);
    send_index(16'd70);
    send_index(16'd90);
    send_index(16'd100);
    send_index(16'd60);
    send_index(16'h5555);
    send_index(16'hAAAA);
    // saturation: high frequency, short period
    set_regs(8'd200, 20'd1000, 16'd65535);
    send_index(16'd65535);
    send_index(16'd65534);
    send_index(16'd65533);
    send_index(16'd0);
    // zero frequency and zero period
    set_regs(8'd0, 20'd500000, 16'd100);
    send_index(16'd101);
    set_regs(8'd25, 20'd0, 16'd100);
    send_index(16'd99);
    // unknown register index is ignored
    drain();
    write_reg(2'd3, 20'hFFFFF);
    send_index(16'd105);
    set_regs(8'd255, 20'hFFFFF, 16'd0);
    send_index(16'd0);
    send_index(16'd1);

    set_regs(8'd25, 20'd500000, 16'd80);
    random_run(300);
    drain(); // sender holds until everything is back
    random_run(50);
    set_regs(8'd1, 20'd1000000, 16'd1000);
    random_run(200);
    set_regs(8'd200, 20'd1, 16'd65535);
    random_run(150);
    set_regs(8'd200, 20'd10000, 16'd0);
    random_run(200);
    set_regs(8'd40, 20'd1000, 16'd32768);
    random_run(200);
    set_regs(8'($urandom_range(1, 200)), 20'($urandom_range(1, 1000000)),
             16'($urandom));
    random_run(330);

    drain();
    if (mismatches == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

[gaussian_derivative_wavelet_gen_unit.f]
rtl/gdw_pkg.sv
rtl/gdw_pipe.sv
rtl/gaussian_derivative_wavelet_gen_unit.sv
rtl/gdw_checker.sv
tb/gaussian_derivative_wavelet_gen_unit_test.sv
